// ===== hdl/clb_pkg.sv =====
// ----------------------------------------------------------------------------
// clb_pkg
// Shared types and constants for the comment and literal blanker.
// ----------------------------------------------------------------------------
package clb_pkg;

    localparam int BYTE_W = 8;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_LINE   = 3'd1,
        MODE_BLOCK  = 3'd2,
        MODE_STRING = 3'd3,
        MODE_CHAR   = 3'd4
    } t_lex_mode;

    // One classified input: one or two output words.
    typedef struct packed {
        logic              two;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic              done;
    } t_entry;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic   avail;
        t_entry entry;
    } t_head;

endpackage

// ===== hdl/c_comment_literal_blanker_core.sv =====
// ----------------------------------------------------------------------------
// c_comment_literal_blanker_core
// Blanks C comments and string/character literals in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive push with i_in_byte and
//   i_end_of_text; a word is taken on a clock edge with push high and full
//   low. Output side is a queue read port: while empty is low the oldest
//   word sits on o_out_byte, o_run_last and o_text_done; pop takes it.
//   Each input byte yields one word, except a slash in code, which is held
//   until the next byte and then yields two words (or none on its own cycle).
//   Each word passes through the queue and then the output register before
//   it shows on the output; the second word of a pair follows the first.
//   Throughput is one input byte per cycle while full is low; the extra
//   output word of a held slash pair is absorbed by the four-entry queue
//   between the lexer front end and the output back end.
//   When pop stays low the output word holds, the queue fills and full
//   rises; input stalls until words drain.
//   Synchronous reset clears lexer state, queue and output valid flag; the
//   word flagged text_done ends a text and the lexer restarts in code mode.
// ----------------------------------------------------------------------------
module c_comment_literal_blanker_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_text_done
);
    import clb_pkg::*;

    logic   accept;
    logic   ent_valid;
    t_entry entry;
    t_head  head;
    logic   q_pop;

    assign accept = push && !full;

    clb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_byte      (i_in_byte),
        .i_last      (i_end_of_text),
        .o_ent_valid (ent_valid),
        .o_entry     (entry)
    );

    clb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ent_valid),
        .i_entry (entry),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_head  (head)
    );

    clb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_byte      (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_done (o_text_done)
    );

endmodule

// ===== hdl/clb_front.sv =====
// ----------------------------------------------------------------------------
// clb_front
// Lexer front end: tracks the lexical mode and turns each accepted byte into
// a queue entry of zero, one or two output words.
// ----------------------------------------------------------------------------
module clb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output logic                  o_ent_valid,
    output clb_pkg::t_entry       o_entry
);
    import clb_pkg::*;

    t_lex_mode r_mode, n_mode;
    logic      r_esc, n_esc;
    logic      r_held, n_held;
    logic      r_star, n_star;

    logic is_slash, is_star, is_nl, is_quote;

    assign is_slash = (i_byte == CH_SLASH);
    assign is_star  = (i_byte == CH_STAR);
    assign is_nl    = (i_byte == CH_NL);
    assign is_quote = (i_byte == CH_DQUOTE) || (i_byte == CH_SQUOTE);

    // Next state
    always_comb begin
        n_mode = r_mode;
        n_esc  = r_esc;
        n_held = r_held;
        n_star = r_star;
        unique case (r_mode)
            MODE_LINE: begin
                if (is_nl) n_mode = MODE_NORMAL;
            end
            MODE_BLOCK: begin
                if (is_nl) begin
                    n_star = 1'b0;
                end else if (r_star && is_slash) begin
                    n_star = 1'b0;
                    n_mode = MODE_NORMAL;
                end else begin
                    n_star = is_star;
                end
            end
            MODE_STRING, MODE_CHAR: begin
                if (is_nl) begin
                    n_mode = MODE_NORMAL;
                    n_esc  = 1'b0;
                end else if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_byte == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if ((r_mode == MODE_STRING && i_byte == CH_DQUOTE) ||
                             (r_mode == MODE_CHAR && i_byte == CH_SQUOTE)) begin
                    n_mode = MODE_NORMAL;
                end
            end
            default: begin
                n_mode = MODE_NORMAL;
                if (r_held && is_slash) begin
                    n_held = 1'b0;
                    n_mode = MODE_LINE;
                end else if (r_held && is_star) begin
                    n_held = 1'b0;
                    n_mode = MODE_BLOCK;
                    n_star = 1'b0;
                end else if (!r_held && is_slash) begin
                    n_held = !i_last;
                end else begin
                    n_held = 1'b0;
                    if (i_byte == CH_DQUOTE) begin
                        n_mode = MODE_STRING;
                        n_esc  = 1'b0;
                    end else if (i_byte == CH_SQUOTE) begin
                        n_mode = MODE_CHAR;
                        n_esc  = 1'b0;
                    end
                end
            end
        endcase
        if (i_last) begin
            n_mode = MODE_NORMAL;
            n_esc  = 1'b0;
            n_held = 1'b0;
            n_star = 1'b0;
        end
    end

    // Entry outputs
    always_comb begin
        o_ent_valid   = i_valid;
        o_entry.two   = 1'b0;
        o_entry.b0    = CH_SPACE;
        o_entry.b1    = CH_SPACE;
        o_entry.done  = i_last;
        unique case (r_mode)
            MODE_LINE, MODE_BLOCK, MODE_STRING, MODE_CHAR: begin
                o_entry.b0 = is_nl ? CH_NL : CH_SPACE;
            end
            default: begin
                if (r_held) begin
                    o_entry.two = 1'b1;
                    if (!is_slash && !is_star) begin
                        o_entry.b0 = CH_SLASH;
                        o_entry.b1 = is_quote ? CH_SPACE : i_byte;
                    end
                end else if (is_slash) begin
                    o_entry.b0 = i_byte;
                    if (!i_last) o_ent_valid = 1'b0;
                end else begin
                    o_entry.b0 = is_quote ? CH_SPACE : i_byte;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_esc  <= 1'b0;
            r_held <= 1'b0;
            r_star <= 1'b0;
        end else if (i_valid) begin
            r_mode <= n_mode;
            r_esc  <= n_esc;
            r_held <= n_held;
            r_star <= n_star;
        end
    end

endmodule

// ===== hdl/clb_queue.sv =====
// ----------------------------------------------------------------------------
// clb_queue
// Short entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module clb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  clb_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output clb_pkg::t_head  o_head
);
    import clb_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic                do_pop;

    assign o_full       = (r_cnt == QCNT_W'(QDEPTH));
    assign o_head.avail = (r_cnt != '0);
    assign o_head.entry = r_mem[r_rd];
    assign do_pop       = i_pop && o_head.avail;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !do_pop) n_cnt = r_cnt + 1'b1;
        else if (!i_push && do_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hdl/clb_back.sv =====
// ----------------------------------------------------------------------------
// clb_back
// Back end: splits queue entries into output words and holds the output
// register.
// ----------------------------------------------------------------------------
module clb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  clb_pkg::t_head i_head,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_byte,
    output logic           o_run_last,
    output logic           o_text_done
);
    import clb_pkg::*;

    logic              r_valid;
    logic              r_half, n_half;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_last, n_last;
    logic              r_done, n_done;
    logic              load, first_of_two;

    assign o_empty      = !r_valid;
    assign load         = i_head.avail && (!r_valid || i_pop);
    assign first_of_two = i_head.entry.two && !r_half;

    always_comb begin
        n_half  = r_half;
        n_byte  = r_half ? i_head.entry.b1 : i_head.entry.b0;
        n_last  = !first_of_two;
        n_done  = !first_of_two && i_head.entry.done;
        o_q_pop = load && !first_of_two;
        if (load) n_half = first_of_two;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_last <= n_last;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) r_valid <= 1'b1;
            else if (i_pop) r_valid <= 1'b0;
            r_half <= n_half;
        end
    end

    assign o_byte      = r_byte;
    assign o_run_last  = r_last;
    assign o_text_done = r_done;

endmodule

// ===== hdl/clb_checker.sv =====
// ----------------------------------------------------------------------------
// clb_checker
// Port-level checks for the blanker core, bound to the top level.
// ----------------------------------------------------------------------------
module clb_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    input  logic       full,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] o_out_byte,
    input  logic       o_run_last,
    input  logic       o_text_done
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not clear after reset");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_text_done) |-> o_run_last)
        else $error("text end word not flagged as run end");

    a_no_full_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !push) |=> !full)
        else $error("full raised without input");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) &&
                              $stable(o_run_last) && $stable(o_text_done)))
        else $error("stalled word changed");

endmodule

bind c_comment_literal_blanker_core clb_checker u_checker (.*);
